// ----- src/set_assoc_byte_cache_unit_assert.svh -----
`ifndef SET_ASSOC_BYTE_CACHE_UNIT_ASSERT_SVH
`define SET_ASSOC_BYTE_CACHE_UNIT_ASSERT_SVH

// expr holds in the same cycle as cond
`define SABC_SAME(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error(msg);

// expr holds in the cycle after cond
`define SABC_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- src/sabc_pkg.sv -----
package sabc_pkg;

    localparam int LINE_BITS_DEF     = 4;
    localparam int WAY_BITS_DEF      = 2;
    localparam int CACHE_BITS_DEF    = 12;
    localparam int MEM_ADDR_BITS_DEF = 20;

    localparam int ADDR_W     = 20;
    localparam int BYTE_W     = 8;
    localparam int LAT_W      = 9;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int LFSR_W     = 16;

    localparam logic                  WRITE_THROUGH_RST  = 1'b0;
    localparam logic                  WRITE_ALLOCATE_RST = 1'b1;
    localparam logic [BYTE_W-1:0]     HIT_LATENCY_RST    = 8'd1;
    localparam logic [BYTE_W-1:0]     BUS_LATENCY_RST    = 8'd1;
    localparam logic [BYTE_W-1:0]     MEMORY_LATENCY_RST = 8'd10;
    localparam logic [LFSR_W-1:0]     LFSR_SEED          = 16'hACE1;
    localparam logic [LFSR_W-1:0]     LFSR_TAPS          = 16'hB400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRITE_THROUGH  = 3'd0,
        CFG_WRITE_ALLOCATE = 3'd1,
        CFG_HIT_LATENCY    = 3'd2,
        CFG_BUS_LATENCY    = 3'd3,
        CFG_MEMORY_LATENCY = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_STORE = 1'b1
    } op_t;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] store_data;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CMP,
        S_HIT_RD,
        S_HIT_CAP,
        S_WB_RD,
        S_WB_WR,
        S_FILL_RD,
        S_FILL_WR,
        S_FINISH,
        S_MERGE,
        S_DONE
    } state_t;

endpackage

// ----- src/sabc_ram.sv -----
module sabc_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/sabc_front.sv -----
`include "set_assoc_byte_cache_unit_assert.svh"

module sabc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [sabc_pkg::ADDR_W-1:0]         s_address,
    input  logic [sabc_pkg::BYTE_W-1:0]         s_store_data,
    input  logic                                accept_en,
    output sabc_pkg::head_t                     head,
    input  logic                                pop
);

    sabc_pkg::item_t q_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;

    assign s_ready = accept_en && (count_reg != 2'd2);
    assign push    = s_valid && s_ready;

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= '{operation: s_operation, address: s_address,
                                   store_data: s_store_data};
        end
    end

    `SABC_SAME(a_fifo_bound, 1'b1, count_reg <= 2'd2, "queue overfilled")
    `SABC_SAME(a_pop_nonempty, pop, count_reg != 2'd0, "pop from empty queue")
    `SABC_SAME(a_full_no_ready, count_reg == 2'd2, !s_ready, "ready while queue full")

endmodule

// ----- src/sabc_back.sv -----
`include "set_assoc_byte_cache_unit_assert.svh"

module sabc_back #(
    parameter int LINE_BITS     = sabc_pkg::LINE_BITS_DEF,
    parameter int WAY_BITS      = sabc_pkg::WAY_BITS_DEF,
    parameter int CACHE_BITS    = sabc_pkg::CACHE_BITS_DEF,
    parameter int MEM_ADDR_BITS = sabc_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sabc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sabc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  sabc_pkg::head_t                     head,
    output logic                                pop,
    output logic                                accept_en,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sabc_pkg::BYTE_W-1:0]         m_load_data,
    output logic                                m_hit,
    output logic [sabc_pkg::LAT_W-1:0]          m_access_latency,
    output logic [sabc_pkg::TOTAL_W-1:0]        m_hit_total,
    output logic [sabc_pkg::TOTAL_W-1:0]        m_miss_total
);

    localparam int BYTE_W     = sabc_pkg::BYTE_W;
    localparam int LAT_W      = sabc_pkg::LAT_W;
    localparam int TOTAL_W    = sabc_pkg::TOTAL_W;
    localparam int LFSR_W     = sabc_pkg::LFSR_W;
    localparam int TAG_SHIFT  = CACHE_BITS - WAY_BITS;
    localparam int IDX_BITS   = CACHE_BITS - WAY_BITS - LINE_BITS;
    localparam int SET_W      = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int WAY_W      = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int NUM_WAYS   = 1 << WAY_BITS;
    localparam int NUM_SETS   = 1 << IDX_BITS;
    localparam int LINE_LEN   = 1 << LINE_BITS;
    localparam int CNT_W      = LINE_BITS + 1;
    localparam int TAG_W      = (MEM_ADDR_BITS > TAG_SHIFT) ? MEM_ADDR_BITS - TAG_SHIFT : 1;
    localparam int TAGS_W     = NUM_WAYS * TAG_W;
    localparam int LIDX_W     = (CACHE_BITS > LINE_BITS) ? CACHE_BITS - LINE_BITS : 1;
    localparam int NUM_LINES  = 1 << LIDX_W;

    sabc_pkg::state_t state_reg, state_next;

    logic                     wt_reg, wa_reg;
    logic [BYTE_W-1:0]        hl_reg, bl_reg, ml_reg;
    logic [MEM_ADDR_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    sabc_pkg::item_t          item_reg, item_next;
    logic [TAGS_W-1:0]        tags_reg, tags_next;
    logic [WAY_W-1:0]         way_reg, way_next;
    logic [TAG_W-1:0]         vtag_reg, vtag_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [BYTE_W-1:0]        rd_reg, rd_next;
    logic                     hit_reg, hit_next;
    logic [LAT_W-1:0]         lat_reg, lat_next;
    logic [TOTAL_W-1:0]       hit_cnt_reg, hit_cnt_next;
    logic [TOTAL_W-1:0]       miss_cnt_reg, miss_cnt_next;
    logic [LFSR_W-1:0]        lfsr_reg, lfsr_next;
    logic                     valid_reg [NUM_LINES];
    logic                     out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]        out_data_reg, out_data_next;
    logic                     out_hit_reg, out_hit_next;
    logic [LAT_W-1:0]         out_lat_reg, out_lat_next;
    logic [TOTAL_W-1:0]       out_hit_tot_reg, out_hit_tot_next;
    logic [TOTAL_W-1:0]       out_miss_tot_reg, out_miss_tot_next;

    logic                     tag_we;
    logic [SET_W-1:0]         tag_waddr, tag_raddr;
    logic [TAGS_W-1:0]        tag_wdata, tag_rdata;
    logic                     data_we;
    logic [CACHE_BITS-1:0]    data_waddr, data_raddr;
    logic [BYTE_W-1:0]        data_wdata, data_rdata;
    logic                     back_we;
    logic [MEM_ADDR_BITS-1:0] back_waddr, back_raddr;
    logic [BYTE_W-1:0]        back_wdata, back_rdata;
    logic                     vb_set;
    logic [LIDX_W-1:0]        vb_idx;

    logic [63:0]              addr64, set64, off64, cnt64, line64;
    logic [TAG_W-1:0]         tag_c;
    logic [LAT_W-1:0]         hit_lat_c, mem_lat_c;
    logic                     hit_c, inv_found_c, store_c, wb_skip_c, last_c;
    logic [WAY_W-1:0]         hit_way_c, inv_way_c, pick_way_c;
    logic [LFSR_W-1:0]        lfsr_step_c;

    sabc_ram #(.DATA_W(TAGS_W), .ADDR_W(SET_W)) u_tag_ram (
        .aclk(aclk), .wr_en(tag_we), .wr_addr(tag_waddr), .wr_data(tag_wdata),
        .rd_addr(tag_raddr), .rd_data(tag_rdata)
    );

    sabc_ram #(.DATA_W(BYTE_W), .ADDR_W(CACHE_BITS)) u_data_ram (
        .aclk(aclk), .wr_en(data_we), .wr_addr(data_waddr), .wr_data(data_wdata),
        .rd_addr(data_raddr), .rd_data(data_rdata)
    );

    sabc_ram #(.DATA_W(BYTE_W), .ADDR_W(MEM_ADDR_BITS)) u_back_ram (
        .aclk(aclk), .wr_en(back_we), .wr_addr(back_waddr), .wr_data(back_wdata),
        .rd_addr(back_raddr), .rd_data(back_rdata)
    );

    assign addr64    = 64'(MEM_ADDR_BITS'(item_reg.address));
    assign set64     = (addr64 >> LINE_BITS) & 64'(NUM_SETS - 1);
    assign off64     = addr64 & 64'(LINE_LEN - 1);
    assign cnt64     = 64'(cnt_reg);
    assign line64    = (set64 << WAY_BITS) | 64'(way_reg);
    assign tag_c     = TAG_W'(addr64 >> TAG_SHIFT);
    assign hit_lat_c = LAT_W'(hl_reg) + LAT_W'(bl_reg);
    assign mem_lat_c = LAT_W'(ml_reg);
    assign store_c   = (item_reg.operation == sabc_pkg::OP_STORE);
    assign wb_skip_c = wt_reg && !wa_reg;
    assign last_c    = (cnt_reg == CNT_W'(LINE_LEN - 1));
    assign accept_en = (state_reg != sabc_pkg::S_CLEAR);
    assign lfsr_step_c = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ sabc_pkg::LFSR_TAPS)
                                     : (lfsr_reg >> 1);

    always_comb begin
        hit_c       = 1'b0;
        hit_way_c   = '0;
        inv_found_c = 1'b0;
        inv_way_c   = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!hit_c && valid_reg[LIDX_W'((set64 << WAY_BITS) | 64'(w))]
                && tag_rdata[w*TAG_W +: TAG_W] == tag_c) begin
                hit_c     = 1'b1;
                hit_way_c = WAY_W'(w);
            end
            if (!inv_found_c && !valid_reg[LIDX_W'((set64 << WAY_BITS) | 64'(w))]) begin
                inv_found_c = 1'b1;
                inv_way_c   = WAY_W'(w);
            end
        end
        pick_way_c = inv_found_c ? inv_way_c
                                 : WAY_W'(64'(lfsr_step_c) & 64'(NUM_WAYS - 1));
    end

    always_comb begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        item_next         = item_reg;
        tags_next         = tags_reg;
        way_next          = way_reg;
        vtag_next         = vtag_reg;
        cnt_next          = cnt_reg;
        rd_next           = rd_reg;
        hit_next          = hit_reg;
        lat_next          = lat_reg;
        hit_cnt_next      = hit_cnt_reg;
        miss_cnt_next     = miss_cnt_reg;
        lfsr_next         = lfsr_reg;
        out_valid_next    = out_valid_reg && !m_ready;
        out_data_next     = out_data_reg;
        out_hit_next      = out_hit_reg;
        out_lat_next      = out_lat_reg;
        out_hit_tot_next  = out_hit_tot_reg;
        out_miss_tot_next = out_miss_tot_reg;
        pop        = 1'b0;
        tag_we     = 1'b0;
        tag_waddr  = SET_W'(set64);
        tag_raddr  = SET_W'((64'(MEM_ADDR_BITS'(head.item.address)) >> LINE_BITS)
                            & 64'(NUM_SETS - 1));
        tag_wdata  = tags_reg;
        data_we    = 1'b0;
        data_waddr = CACHE_BITS'((line64 << LINE_BITS) | cnt64);
        data_raddr = CACHE_BITS'((line64 << LINE_BITS) | cnt64);
        data_wdata = back_rdata;
        back_we    = 1'b0;
        back_waddr = MEM_ADDR_BITS'(addr64);
        back_raddr = MEM_ADDR_BITS'((addr64 & ~64'(LINE_LEN - 1)) + cnt64);
        back_wdata = item_reg.store_data;
        vb_set     = 1'b0;
        vb_idx     = LIDX_W'(line64);

        unique case (state_reg)
            sabc_pkg::S_CLEAR: begin
                back_we      = 1'b1;
                back_waddr   = clr_cnt_reg;
                back_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg) begin
                    state_next = sabc_pkg::S_IDLE;
                end
            end
            sabc_pkg::S_IDLE: begin
                if (head.valid) begin
                    pop        = 1'b1;
                    item_next  = head.item;
                    state_next = sabc_pkg::S_CMP;
                end
            end
            sabc_pkg::S_CMP: begin
                tags_next = tag_rdata;
                rd_next   = '0;
                cnt_next  = '0;
                if (hit_c) begin
                    hit_next     = 1'b1;
                    hit_cnt_next = hit_cnt_reg + 1'b1;
                    way_next     = hit_way_c;
                    if (store_c) begin
                        lat_next   = wt_reg ? mem_lat_c : hit_lat_c;
                        state_next = sabc_pkg::S_MERGE;
                    end else begin
                        lat_next   = hit_lat_c;
                        state_next = sabc_pkg::S_HIT_RD;
                    end
                end else begin
                    hit_next      = 1'b0;
                    miss_cnt_next = miss_cnt_reg + 1'b1;
                    lat_next      = mem_lat_c;
                    if (store_c && !wa_reg) begin
                        back_we    = 1'b1;
                        state_next = sabc_pkg::S_DONE;
                    end else begin
                        way_next  = pick_way_c;
                        vtag_next = tag_rdata[pick_way_c*TAG_W +: TAG_W];
                        if (!inv_found_c) begin
                            lfsr_next = lfsr_step_c;
                        end
                        state_next = (!inv_found_c && !wb_skip_c) ? sabc_pkg::S_WB_RD
                                                                  : sabc_pkg::S_FILL_RD;
                    end
                end
            end
            sabc_pkg::S_HIT_RD: begin
                data_raddr = CACHE_BITS'((line64 << LINE_BITS) | off64);
                state_next = sabc_pkg::S_HIT_CAP;
            end
            sabc_pkg::S_HIT_CAP: begin
                rd_next    = data_rdata;
                state_next = sabc_pkg::S_DONE;
            end
            sabc_pkg::S_WB_RD: begin
                state_next = sabc_pkg::S_WB_WR;
            end
            sabc_pkg::S_WB_WR: begin
                back_we    = 1'b1;
                back_waddr = MEM_ADDR_BITS'(((64'(vtag_reg) << TAG_SHIFT)
                                             | (set64 << LINE_BITS)) + cnt64);
                back_wdata = data_rdata;
                if (last_c) begin
                    cnt_next   = '0;
                    state_next = sabc_pkg::S_FILL_RD;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = sabc_pkg::S_WB_RD;
                end
            end
            sabc_pkg::S_FILL_RD: begin
                state_next = sabc_pkg::S_FILL_WR;
            end
            sabc_pkg::S_FILL_WR: begin
                data_we = 1'b1;
                if (!store_c && cnt64 == off64) begin
                    rd_next = back_rdata;
                end
                if (last_c) begin
                    state_next = sabc_pkg::S_FINISH;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = sabc_pkg::S_FILL_RD;
                end
            end
            sabc_pkg::S_FINISH: begin
                tag_we = 1'b1;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (WAY_W'(w) == way_reg) begin
                        tag_wdata[w*TAG_W +: TAG_W] = tag_c;
                    end
                end
                vb_set     = 1'b1;
                state_next = store_c ? sabc_pkg::S_MERGE : sabc_pkg::S_DONE;
            end
            sabc_pkg::S_MERGE: begin
                data_we    = 1'b1;
                data_waddr = CACHE_BITS'((line64 << LINE_BITS) | off64);
                data_wdata = item_reg.store_data;
                back_we    = wt_reg;
                state_next = sabc_pkg::S_DONE;
            end
            sabc_pkg::S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next    = 1'b1;
                    out_data_next     = rd_reg;
                    out_hit_next      = hit_reg;
                    out_lat_next      = lat_reg;
                    out_hit_tot_next  = hit_cnt_reg;
                    out_miss_tot_next = miss_cnt_reg;
                    state_next        = sabc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sabc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sabc_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            lfsr_reg      <= sabc_pkg::LFSR_SEED;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LINES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
            if (vb_set) begin
                valid_reg[vb_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg         <= item_next;
        tags_reg         <= tags_next;
        way_reg          <= way_next;
        vtag_reg         <= vtag_next;
        cnt_reg          <= cnt_next;
        rd_reg           <= rd_next;
        hit_reg          <= hit_next;
        lat_reg          <= lat_next;
        out_data_reg     <= out_data_next;
        out_hit_reg      <= out_hit_next;
        out_lat_reg      <= out_lat_next;
        out_hit_tot_reg  <= out_hit_tot_next;
        out_miss_tot_reg <= out_miss_tot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wt_reg <= sabc_pkg::WRITE_THROUGH_RST;
            wa_reg <= sabc_pkg::WRITE_ALLOCATE_RST;
            hl_reg <= sabc_pkg::HIT_LATENCY_RST;
            bl_reg <= sabc_pkg::BUS_LATENCY_RST;
            ml_reg <= sabc_pkg::MEMORY_LATENCY_RST;
        end else if (cfg_wr_en) begin
            unique case (sabc_pkg::cfg_index_t'(cfg_index))
                sabc_pkg::CFG_WRITE_THROUGH:  wt_reg <= cfg_wdata[0];
                sabc_pkg::CFG_WRITE_ALLOCATE: wa_reg <= cfg_wdata[0];
                sabc_pkg::CFG_HIT_LATENCY:    hl_reg <= cfg_wdata;
                sabc_pkg::CFG_BUS_LATENCY:    bl_reg <= cfg_wdata;
                sabc_pkg::CFG_MEMORY_LATENCY: ml_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_load_data      = out_data_reg;
    assign m_hit            = out_hit_reg;
    assign m_access_latency = out_lat_reg;
    assign m_hit_total      = out_hit_tot_reg;
    assign m_miss_total     = out_miss_tot_reg;

    `SABC_NEXT(a_hit_path, state_reg == sabc_pkg::S_CMP && hit_c, state_reg == sabc_pkg::S_HIT_RD || state_reg == sabc_pkg::S_MERGE, "hit took miss path")
    `SABC_SAME(a_clear_no_pop, state_reg == sabc_pkg::S_CLEAR, !pop && !out_valid_reg, "word taken during clear")
    `SABC_SAME(a_cnt_bound, state_reg == sabc_pkg::S_FILL_WR || state_reg == sabc_pkg::S_WB_WR, cnt_reg < CNT_W'(LINE_LEN), "line walk past end")

endmodule

// ----- src/set_assoc_byte_cache_unit.sv -----
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | s_operation, s_address, s_store_data
// m_      | out       | m_valid / m_ready  | m_load_data, m_hit, m_access_latency,
//         |           |                    | m_hit_total, m_miss_total
// cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
// Allocating miss: a line fill, preceded by a write-back of the line when a valid victim
// is evicted (not under write-through without write-allocate); the line walk is byte-wide,
// a read and a write state a byte through the registered-read memories. After reset the
// backing memory is zeroed, one byte a cycle; no word is accepted meanwhile. A two-entry
// queue accepts words while a result waits.
module set_assoc_byte_cache_unit #(
    parameter int LINE_BITS     = sabc_pkg::LINE_BITS_DEF,
    parameter int WAY_BITS      = sabc_pkg::WAY_BITS_DEF,
    parameter int CACHE_BITS    = sabc_pkg::CACHE_BITS_DEF,
    parameter int MEM_ADDR_BITS = sabc_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sabc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sabc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [sabc_pkg::ADDR_W-1:0]         s_address,
    input  logic [sabc_pkg::BYTE_W-1:0]         s_store_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sabc_pkg::BYTE_W-1:0]         m_load_data,
    output logic                                m_hit,
    output logic [sabc_pkg::LAT_W-1:0]          m_access_latency,
    output logic [sabc_pkg::TOTAL_W-1:0]        m_hit_total,
    output logic [sabc_pkg::TOTAL_W-1:0]        m_miss_total
);

    sabc_pkg::head_t head;
    logic            pop;
    logic            accept_en;

    sabc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_address(s_address), .s_store_data(s_store_data),
        .accept_en(accept_en), .head(head), .pop(pop)
    );

    sabc_back #(
        .LINE_BITS(LINE_BITS), .WAY_BITS(WAY_BITS),
        .CACHE_BITS(CACHE_BITS), .MEM_ADDR_BITS(MEM_ADDR_BITS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .head(head), .pop(pop), .accept_en(accept_en),
        .m_valid(m_valid), .m_ready(m_ready), .m_load_data(m_load_data), .m_hit(m_hit),
        .m_access_latency(m_access_latency), .m_hit_total(m_hit_total),
        .m_miss_total(m_miss_total)
    );

endmodule
